>>> rtl/acir_pkg.sv
package acir_pkg;

  // Frame geometry
  localparam int FrameBytes = 19;
  localparam int MsgChars   = 2 * FrameBytes + 1;
  localparam int IdxW       = $clog2(MsgChars);
  localparam int ByteIdxW   = $clog2(FrameBytes);

  // Byte positions that are filled per command
  localparam int PosMode     = 5;
  localparam int PosTemp     = 6;
  localparam int PosFanSwing = 8;
  localparam int PosOption   = 13;
  localparam int PosCheck    = 18;

  // Temperature limits
  localparam logic [7:0] TempMin = 8'd16;
  localparam logic [7:0] TempMax = 8'd31;

  // Option codes on the input
  localparam logic [1:0] OptNone     = 2'd0;
  localparam logic [1:0] OptQuiet    = 2'd1;
  localparam logic [1:0] OptPowerful = 2'd2;

  // Mode codes on the input
  localparam logic [1:0] ModeAuto = 2'd0;
  localparam logic [1:0] ModeCool = 2'd1;
  localparam logic [1:0] ModeHeat = 2'd2;
  localparam logic [1:0] ModeDry  = 2'd3;

  localparam logic [7:0] PowerOnBit  = 8'b1000_0000;
  localparam logic [7:0] FanLowest   = 8'h0C;

  // ASCII characters
  localparam logic [6:0] CharStart  = 7'h49;  // 'I'
  localparam logic [6:0] CharZero   = 7'h30;  // '0'
  localparam logic [6:0] CharLetter = 7'h37;  // 'A' - 10

  // Constant frame, index 0 is sent first
  localparam logic [FrameBytes-1:0][7:0] FrameTemplate = {
    8'h00, 8'h60, 8'h00, 8'h01, 8'h00, 8'h00, 8'h06, 8'h60, 8'h00, 8'h00,
    8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h20, 8'h07, 8'h04, 8'h40
  };

  typedef logic [FrameBytes-1:0][7:0] frame_t;

  // One command
  typedef struct packed {
    logic       power_on;
    logic [1:0] mode;
    logic [2:0] fan_level;
    logic [2:0] swing_level;
    logic [7:0] temperature;
    logic [1:0] option;
  } in_req_t;

  // One character of the message
  typedef struct packed {
    logic [6:0] char_code;
    logic       last;
  } out_req_t;

  // Bytes that change from command to command
  typedef struct packed {
    logic [7:0] mode_byte;
    logic [7:0] temp_byte;
    logic [7:0] fan_swing_byte;
    logic [7:0] option_byte;
  } fill_t;

  function automatic logic [7:0] bit_mirror(input logic [7:0] v);
    logic [7:0] r;
    for (int k = 0; k < 8; k++) begin
      r[7-k] = v[k];
    end
    return r;
  endfunction

  function automatic logic [6:0] hex_char(input logic [3:0] nib);
    logic [6:0] base;
    base = (nib < 4'd10) ? CharZero : CharLetter;
    return base + {3'b000, nib};
  endfunction

  function automatic logic [7:0] mode_code(input logic [1:0] md);
    logic [7:0] c;
    unique case (md)
      ModeAuto: c = 8'h00;
      ModeCool: c = 8'h0C;
      ModeHeat: c = 8'h02;
      ModeDry:  c = 8'h04;
      default:  c = 8'h00;
    endcase
    return c;
  endfunction

  // Levels six and seven fall back to auto
  function automatic logic [7:0] fan_code(input logic [2:0] fl);
    logic [7:0] c;
    unique case (fl)
      3'd1:    c = 8'h0C;
      3'd2:    c = 8'h02;
      3'd3:    c = 8'h0A;
      3'd4:    c = 8'h06;
      3'd5:    c = 8'h0E;
      default: c = 8'h05;
    endcase
    return c;
  endfunction

  function automatic logic [7:0] swing_code(input logic [2:0] sl);
    logic [7:0] c;
    unique case (sl)
      3'd1:    c = 8'h80;
      3'd2:    c = 8'h40;
      3'd3:    c = 8'hC0;
      3'd4:    c = 8'h20;
      3'd5:    c = 8'hA0;
      default: c = 8'hF0;
    endcase
    return c;
  endfunction

  // Option three falls back to none
  function automatic logic [7:0] option_code(input logic [1:0] op);
    logic [7:0] c;
    unique case (op)
      OptQuiet:    c = 8'h04;
      OptPowerful: c = 8'h80;
      default:     c = 8'h00;
    endcase
    return c;
  endfunction

  // Mirrored sum of the constant bytes, worked out at elaboration
  function automatic logic [7:0] template_sum();
    logic [7:0] s;
    s = 8'h00;
    for (int b = 0; b < FrameBytes; b++) begin
      s = s + bit_mirror(FrameTemplate[b]);
    end
    return s;
  endfunction

  localparam logic [7:0] TemplateSum = template_sum();

endpackage

>>> rtl/acir_frame_build.sv
module acir_frame_build (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  acir_pkg::in_req_t in_req_i,
  output logic              frame_valid_o,
  input  logic              frame_ready_i,
  output acir_pkg::frame_t  frame_o
);
  import acir_pkg::*;

  logic       s1_valid_q, s2_valid_q;
  logic       s1_en, s2_en;
  fill_t      s1_fill_d, s1_fill_q, s2_fill_q;
  logic [7:0] check_d, check_q;
  logic [7:0] temp_clamp;
  logic [7:0] fan_sel;

  // Stall control: a stage loads when it is empty or its content moves on
  assign s2_en      = !s2_valid_q || frame_ready_i;
  assign s1_en      = !s1_valid_q || s2_en;
  assign in_ready_o = s1_en;

  // Stage 1: decode the command into frame bytes
  always_comb begin
    temp_clamp = in_req_i.temperature;
    if (temp_clamp > TempMax) begin
      temp_clamp = TempMax;
    end
    if (temp_clamp < TempMin) begin
      temp_clamp = TempMin;
    end
    fan_sel = (in_req_i.option == OptQuiet) ? FanLowest : fan_code(in_req_i.fan_level);
    s1_fill_d.mode_byte      = (in_req_i.power_on ? PowerOnBit : 8'h00)
                             | mode_code(in_req_i.mode);
    s1_fill_d.temp_byte      = bit_mirror({temp_clamp[6:0], 1'b0});
    s1_fill_d.fan_swing_byte = swing_code(in_req_i.swing_level) | fan_sel;
    s1_fill_d.option_byte    = option_code(in_req_i.option);
  end

  // Stage 2: checksum over the mirrored bytes
  assign check_d = bit_mirror(TemplateSum
                            + bit_mirror(s1_fill_q.mode_byte)
                            + bit_mirror(s1_fill_q.temp_byte)
                            + bit_mirror(s1_fill_q.fan_swing_byte)
                            + bit_mirror(s1_fill_q.option_byte));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
    end else begin
      if (s1_en) begin
        s1_valid_q <= in_valid_i;
      end
      if (s2_en) begin
        s2_valid_q <= s1_valid_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_en && in_valid_i) begin
      s1_fill_q <= s1_fill_d;
    end
    if (s2_en && s1_valid_q) begin
      s2_fill_q <= s1_fill_q;
      check_q   <= check_d;
    end
  end

  // Merge the filled bytes into the template
  always_comb begin
    frame_o              = FrameTemplate;
    frame_o[PosMode]     = s2_fill_q.mode_byte;
    frame_o[PosTemp]     = s2_fill_q.temp_byte;
    frame_o[PosFanSwing] = s2_fill_q.fan_swing_byte;
    frame_o[PosOption]   = s2_fill_q.option_byte;
    frame_o[PosCheck]    = check_q;
  end

  assign frame_valid_o = s2_valid_q;

endmodule

>>> rtl/acir_char_ser.sv
module acir_char_ser (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               frame_valid_i,
  output logic               frame_ready_o,
  input  acir_pkg::frame_t   frame_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output acir_pkg::out_req_t out_req_o
);
  import acir_pkg::*;

  localparam logic [IdxW-1:0] LastIdx = IdxW'(MsgChars - 1);

  logic                busy_q;
  logic [IdxW-1:0]     idx_q;
  frame_t              frame_q;
  logic                out_valid_q;
  out_req_t            out_q, out_d;
  logic                out_en, emit, at_last, load;
  logic [IdxW-1:0]     pos;
  logic [ByteIdxW-1:0] byte_idx;
  logic [7:0]          cur_byte;
  logic [3:0]          nib;

  // Output register frees when empty or taken
  assign out_en        = !out_valid_q || out_ready_i;
  assign emit          = busy_q && out_en;
  assign at_last       = (idx_q == LastIdx);
  assign frame_ready_o = !busy_q || (emit && at_last);
  assign load          = frame_valid_i && frame_ready_o;

  // Character select: start mark, then two hex digits per byte
  assign pos      = idx_q - IdxW'(1);
  assign byte_idx = pos[ByteIdxW:1];
  assign cur_byte = frame_q[byte_idx];
  assign nib      = pos[0] ? cur_byte[3:0] : cur_byte[7:4];

  always_comb begin
    out_d.char_code = (idx_q == '0) ? CharStart : hex_char(nib);
    out_d.last      = at_last;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (load) begin
        busy_q <= 1'b1;
        idx_q  <= '0;
      end else if (emit) begin
        if (at_last) begin
          busy_q <= 1'b0;
        end
        idx_q <= idx_q + IdxW'(1);
      end
      if (out_en) begin
        out_valid_q <= busy_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      frame_q <= frame_i;
    end
    if (emit) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_q;

endmodule

>>> rtl/ac_ir_frame_hex_encoder.sv
// Air-conditioner remote frame encoder. Each accepted command yields a
// 39-character message: 'I' followed by the 19-byte frame as uppercase hex,
// high nibble first, with last set on the final character. The character
// serializer sends one character per cycle while the output is not stalled;
// two decode/checksum stages ahead of it let the next command be
// accepted and prepared while the current message is still going out, so
// back-to-back commands stream with no gap. An accepted command goes through
// the decode, checksum, frame and output registers to its first character.
module ac_ir_frame_hex_encoder (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  acir_pkg::in_req_t  in_req_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output acir_pkg::out_req_t out_req_o
);
  import acir_pkg::*;

  logic   frame_valid, frame_ready;
  frame_t frame;

  acir_frame_build u_build (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .in_ready_o    (in_ready_o),
    .in_req_i      (in_req_i),
    .frame_valid_o (frame_valid),
    .frame_ready_i (frame_ready),
    .frame_o       (frame)
  );

  acir_char_ser u_ser (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .frame_valid_i (frame_valid),
    .frame_ready_o (frame_ready),
    .frame_i       (frame),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .out_req_o     (out_req_o)
  );

endmodule

>>> verif/tb_ac_ir_frame_hex_encoder.sv
`timescale 1ns / 1ps

module tb_ac_ir_frame_hex_encoder;
  import acir_pkg::*;

  localparam int NumDirected = 22;
  localparam int NumRandom   = 200;
  localparam int CalmTail    = 40;
  localparam int TailCycles  = 20;
  localparam int NoPin       = -1;

  // Option three on the input has no code of its own
  localparam logic [1:0] OptSpare = 2'd3;

  localparam logic [6:0] AsciiI = 7'h49;  // 'I'

  // Fixed frame, first byte sent first
  localparam logic [7:0] StockBytes [FrameBytes] = '{
    8'h40, 8'h04, 8'h07, 8'h20, 8'h00, 8'h00, 8'h00, 8'h01, 8'h00, 8'h00,
    8'h00, 8'h60, 8'h06, 8'h00, 8'h00, 8'h01, 8'h00, 8'h60, 8'h00
  };

  // One directed command, with one frame byte typed in where it is obvious
  typedef struct {
    in_req_t    cmd;
    int         pin_pos;
    logic [7:0] pin_val;
  } stim_row_t;

  logic     clk_i     = 1'b0;
  logic     rst_ni    = 1'b0;
  logic     in_valid  = 1'b0;
  logic     in_ready;
  in_req_t  in_req    = '0;
  logic     out_valid;
  logic     out_ready = 1'b0;
  out_req_t out_req;

  int         pin_pos = NoPin;
  logic [7:0] pin_val = 8'h00;
  bit         calm    = 1'b0;
  int         mismatches = 0;
  out_req_t   expected_chars [$];

  // Directed commands: field extremes, every mode, fallbacks, quiet override
  stim_row_t directed [NumDirected] = '{
    '{'{1'b0, ModeAuto, 3'd0, 3'd0, 8'd16,  OptNone},     PosCheck,    8'h82},
    '{'{1'b0, ModeAuto, 3'd0, 3'd0, 8'd0,   OptNone},     PosTemp,     8'h04},
    '{'{1'b1, ModeCool, 3'd1, 3'd1, 8'd255, OptNone},     PosTemp,     8'h7C},
    '{'{1'b1, ModeHeat, 3'd2, 3'd2, 8'd15,  OptNone},     PosTemp,     8'h04},
    '{'{1'b0, ModeDry,  3'd3, 3'd3, 8'd32,  OptNone},     PosTemp,     8'h7C},
    '{'{1'b1, ModeDry,  3'd4, 3'd4, 8'd31,  OptPowerful}, PosMode,     8'h84},
    '{'{1'b1, ModeCool, 3'd5, 3'd5, 8'd20,  OptNone},     PosMode,     8'h8C},
    '{'{1'b0, ModeHeat, 3'd0, 3'd1, 8'd24,  OptNone},     PosMode,     8'h02},
    '{'{1'b1, ModeAuto, 3'd2, 3'd0, 8'd17,  OptNone},     PosMode,     8'h80},
    // fan and swing levels past five fall back to auto
    '{'{1'b0, ModeAuto, 3'd6, 3'd1, 8'd22,  OptNone},     PosFanSwing, 8'h85},
    '{'{1'b0, ModeCool, 3'd7, 3'd7, 8'd25,  OptNone},     PosFanSwing, 8'hF5},
    '{'{1'b0, ModeHeat, 3'd3, 3'd6, 8'd26,  OptNone},     PosFanSwing, 8'hFA},
    // quiet forces the lowest fan
    '{'{1'b1, ModeCool, 3'd5, 3'd0, 8'd23,  OptQuiet},    PosFanSwing, 8'hFC},
    '{'{1'b0, ModeAuto, 3'd1, 3'd4, 8'd18,  OptQuiet},    PosOption,   8'h04},
    '{'{1'b1, ModeHeat, 3'd3, 3'd5, 8'd30,  OptPowerful}, PosOption,   8'h80},
    '{'{1'b0, ModeDry,  3'd2, 3'd3, 8'd19,  OptSpare},    PosOption,   8'h00},
    '{'{1'b1, ModeAuto, 3'd5, 3'd2, 8'd21,  OptNone},     PosFanSwing, 8'h4E},
    '{'{1'b1, ModeCool, 3'd4, 3'd3, 8'd28,  OptNone},     PosFanSwing, 8'hC6},
    '{'{1'b0, ModeAuto, 3'd0, 3'd0, 8'hAA,  OptNone},     PosTemp,     8'h7C},
    '{'{1'b1, ModeDry,  3'd7, 3'd6, 8'h55,  OptSpare},    PosTemp,     8'h7C},
    '{'{1'b1, ModeDry,  3'd7, 3'd7, 8'hFF,  OptQuiet},    PosFanSwing, 8'hFC},
    '{'{1'b0, ModeAuto, 3'd4, 3'd1, 8'd16,  OptNone},     PosFanSwing, 8'h86}
  };

  ac_ir_frame_hex_encoder u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_ready_o  (in_ready),
    .in_req_i    (in_req),
    .out_valid_o (out_valid),
    .out_ready_i (out_ready),
    .out_req_o   (out_req)
  );

  always #4 clk_i = ~clk_i;

  function automatic logic [7:0] flip_byte(input logic [7:0] v);
    return {<<{v}};
  endfunction

  // Uppercase hex digit
  function automatic logic [6:0] ascii_hex(input logic [3:0] nib);
    return (nib < 4'd10) ? 7'h30 + 7'(nib) : 7'h37 + 7'(nib);
  endfunction

  // Build the frame for one command and queue its 39 characters
  function automatic void queue_message(input in_req_t cmd, input int pos,
                                        input logic [7:0] val);
    logic [7:0] frame [FrameBytes];
    logic [7:0] fan;
    logic [7:0] deg;
    logic [7:0] sum;
    out_req_t   ch;
    frame = StockBytes;

    case (cmd.fan_level)
      3'd1:    fan = 8'h0C;
      3'd2:    fan = 8'h02;
      3'd3:    fan = 8'h0A;
      3'd4:    fan = 8'h06;
      3'd5:    fan = 8'h0E;
      default: fan = 8'h05;
    endcase
    if (cmd.option == OptQuiet) fan = 8'h0C;

    case (cmd.option)
      OptQuiet:    frame[PosOption] = 8'h04;
      OptPowerful: frame[PosOption] = 8'h80;
      default:     frame[PosOption] = 8'h00;
    endcase

    case (cmd.mode)
      ModeCool: frame[PosMode] = 8'h0C;
      ModeHeat: frame[PosMode] = 8'h02;
      ModeDry:  frame[PosMode] = 8'h04;
      default:  frame[PosMode] = 8'h00;
    endcase
    if (cmd.power_on) frame[PosMode] |= 8'h80;

    deg = cmd.temperature;
    if (deg > TempMax) deg = TempMax;
    if (deg < TempMin) deg = TempMin;
    frame[PosTemp] = flip_byte(deg << 1);

    case (cmd.swing_level)
      3'd1:    frame[PosFanSwing] = 8'h80 | fan;
      3'd2:    frame[PosFanSwing] = 8'h40 | fan;
      3'd3:    frame[PosFanSwing] = 8'hC0 | fan;
      3'd4:    frame[PosFanSwing] = 8'h20 | fan;
      3'd5:    frame[PosFanSwing] = 8'hA0 | fan;
      default: frame[PosFanSwing] = 8'hF0 | fan;
    endcase

    // checksum byte is still zero while summing
    sum = 8'h00;
    for (int b = 0; b < FrameBytes; b++) sum += flip_byte(frame[b]);
    frame[PosCheck] = flip_byte(sum);

    if (pos != NoPin) frame[pos] = val;

    ch.char_code = AsciiI;
    ch.last      = 1'b0;
    expected_chars.push_back(ch);
    for (int b = 0; b < FrameBytes; b++) begin
      ch.char_code = ascii_hex(frame[b][7:4]);
      ch.last      = 1'b0;
      expected_chars.push_back(ch);
      ch.char_code = ascii_hex(frame[b][3:0]);
      ch.last      = (b == FrameBytes - 1);
      expected_chars.push_back(ch);
    end
  endfunction

  // Present one command, with an occasional gap ahead of it
  task automatic send_cmd(input in_req_t cmd, input int pos, input logic [7:0] val);
    int gap;
    gap = 0;
    if (!calm && $urandom_range(0, 3) == 0) gap = $urandom_range(1, 12);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    in_valid <= 1'b1;
    in_req   <= cmd;
    pin_pos  <= pos;
    pin_val  <= val;
    do @(posedge clk_i); while (!in_ready);
    @(negedge clk_i);
  endtask

  // Hold off until every queued character has come out
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(negedge clk_i);
    while (expected_chars.size() != 0) @(negedge clk_i);
  endtask

  // Request side
  initial begin : stimulus
    in_req_t cmd;
    repeat (9) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed[i]) send_cmd(directed[i].cmd, directed[i].pin_pos, directed[i].pin_val);
    wait_drained();

    for (int n = 0; n < NumRandom; n++) begin
      if (n == NumRandom / 2) wait_drained();
      if (n == NumRandom - CalmTail) calm = 1'b1;
      cmd.power_on    = 1'($urandom_range(0, 1));
      cmd.mode        = 2'($urandom_range(0, 3));
      cmd.fan_level   = 3'($urandom_range(0, 7));
      cmd.swing_level = 3'($urandom_range(0, 7));
      // sometimes near the legal band, mostly anywhere
      if ($urandom_range(0, 2) == 0) cmd.temperature = 8'($urandom_range(10, 37));
      else cmd.temperature = 8'($urandom_range(0, 255));
      cmd.option      = 2'($urandom_range(0, 3));
      send_cmd(cmd, NoPin, 8'h00);
    end
    in_valid <= 1'b0;

    while (expected_chars.size() != 0) @(negedge clk_i);
    repeat (TailCycles) @(negedge clk_i);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

  // Result side back-pressure, in bursts
  initial begin : sink
    int span;
    @(posedge rst_ni);
    forever begin
      if (!calm && $urandom_range(0, 3) == 0) begin
        span = $urandom_range(1, 12);
        out_ready <= 1'b0;
      end else begin
        span = $urandom_range(1, 20);
        out_ready <= 1'b1;
      end
      repeat (span) @(negedge clk_i);
    end
  end

  // Predict on accepted commands, check accepted characters
  always @(posedge clk_i) begin
    out_req_t want;
    if (rst_ni && in_valid && in_ready) queue_message(in_req, pin_pos, pin_val);
    if (rst_ni && out_valid && out_ready) begin
      if (expected_chars.size() == 0) begin
        if (mismatches < 10)
          $display("%0t: unexpected char %h last %b", $realtime, out_req.char_code,
                   out_req.last);
        mismatches++;
      end else begin
        want = expected_chars.pop_front();
        if (out_req.char_code !== want.char_code || out_req.last !== want.last) begin
          if (mismatches < 10)
            $display("%0t: char exp %h got %h, last exp %b got %b", $realtime,
                     want.char_code, out_req.char_code, want.last, out_req.last);
          mismatches++;
        end
      end
    end
  end

  // Watchdog
  initial begin : watchdog
    #5_000_000;
    $display("end of test: mismatches");
    $finish;
  end

endmodule
